@@ src/base58_encoder_core_assert.svh @@
// Assertion macros shared by the encoder RTL.
// Each use expands to one labeled concurrent assertion clocked on clk, off while rst is high.
`ifndef BASE58_ENCODER_CORE_ASSERT_SVH
`define BASE58_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication.
`define B58_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define B58_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/b58_pkg.sv @@
package b58_pkg;

  typedef enum logic [1:0] {
    S_LOAD,
    S_DIV,
    S_FETCH,
    S_WAIT
  } b58_state_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic clear;
  } b58_cell_ctl_t;

  localparam int unsigned B58_RADIX = 58;
  // floor(x / 58) == (x * B58_RECIP) >> B58_SHIFT for every x below 58 * 256
  localparam int unsigned B58_RECIP = 18079;
  localparam int unsigned B58_SHIFT = 20;

  localparam logic [6:0] B58_ONE = 7'h31;

  // Digit value to ASCII; the top six entries are never addressed.
  localparam logic [7:0] B58_ALPHA [64] = '{
    "1", "2", "3", "4", "5", "6", "7", "8", "9",
    "A", "B", "C", "D", "E", "F", "G", "H", "J", "K", "L", "M", "N",
    "P", "Q", "R", "S", "T", "U", "V", "W", "X", "Y", "Z",
    "a", "b", "c", "d", "e", "f", "g", "h", "i", "j", "k", "m", "n",
    "o", "p", "q", "r", "s", "t", "u", "v", "w", "x", "y", "z",
    "1", "1", "1", "1", "1", "1"
  };

  function automatic logic [6:0] b58_char(input logic [5:0] idx);
    logic [7:0] c;
    c = B58_ALPHA[idx];
    return c[6:0];
  endfunction

endpackage

@@ src/b58_ram.sv @@
module b58_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/b58_cell.sv @@
module b58_cell (
  input  logic                  clk,
  input  b58_pkg::b58_cell_ctl_t ctl,
  input  logic [7:0]            data_byte,
  input  logic [7:0]            shift_in,
  output logic [7:0]            value
);

  // Shift during a division pass; otherwise take a byte or clear.
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      value <= shift_in;
    end else if (ctl.load) begin
      value <= data_byte;
    end else if (ctl.clear) begin
      value <= '0;
    end
  end

endmodule

@@ src/b58_div58.sv @@
module b58_div58 (
  input  logic [5:0] rem_in,
  input  logic [7:0] byte_in,
  output logic [7:0] quo,
  output logic [5:0] rem_out
);

  import b58_pkg::*;

  logic [13:0] cur;
  logic [28:0] prod;
  logic [13:0] q58;
  logic [13:0] diff;

  always_comb begin
    cur     = {rem_in, byte_in};
    prod    = 29'(cur) * 29'(B58_RECIP);
    quo     = prod[B58_SHIFT +: 8];
    // q * 58 as shifts: 64q - 4q - 2q
    q58     = {quo, 6'b0} - {4'b0, quo, 2'b0} - {5'b0, quo, 1'b0};
    diff    = cur - q58;
    rem_out = diff[5:0];
  end

endmodule

@@ src/base58_encoder_core.sv @@
// Base58 encoder: one request byte per cycle while loading, least significant first.
// After the closing byte, each output digit takes one division pass over the cell row,
// then each character is fetched through the digit store read port; no new request is
// taken until the last character has been loaded into the output register.
// Synchronous active-high rst clears all control state; byte cells and digit store
// hold no reset value.
`include "base58_encoder_core_assert.svh"

module base58_encoder_core #(
  parameter int MAX_BYTES = 32,
  parameter int MAX_CHARS = 44
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       data_valid,
  output logic       data_ready,
  output logic [6:0] out_char,
  output logic       last_char,
  output logic       char_valid,
  input  logic       char_ready
);

  import b58_pkg::*;

  // Upper bound on base58 digits of a MAX_BYTES number (log 256 / log 58 < 1.366).
  localparam int DIG_DEPTH = (MAX_BYTES * 1366) / 1000 + 2;
  localparam int AW  = $clog2(DIG_DEPTH);
  localparam int DCW = $clog2(DIG_DEPTH + 1);
  localparam int CW  = $clog2(MAX_BYTES + 1);
  localparam int PW  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int KW  = $clog2(MAX_CHARS + 1);
  localparam int SW  = DCW + CW + 1;

  b58_state_t state, state_next;

  // Control registers
  logic [CW-1:0]  byte_count;   // bytes held in the cell row
  logic [CW-1:0]  zrun;         // current run of zero bytes at the top end
  logic [CW-1:0]  zeros;        // leading zero bytes of the closed request
  logic [DCW-1:0] dcnt;         // digits written to the store
  logic [KW-1:0]  k;            // characters emitted so far
  logic [PW-1:0]  cyc;          // position within a division pass
  logic [5:0]     rem;          // running remainder of the pass
  logic           nz;           // a nonzero quotient byte seen this pass

  // Datapath
  logic [7:0]     cell_q  [MAX_BYTES];
  logic [7:0]     cell_in [MAX_BYTES];
  b58_cell_ctl_t  cell_ctl [MAX_BYTES];
  logic [7:0]     quo;
  logic [5:0]     rem_out;
  logic [5:0]     rdata;

  logic           accept;
  logic           store;
  logic [CW-1:0]  stored_n;
  logic [CW-1:0]  zrun_n;
  logic           pass_end;
  logic           more;
  logic [SW-1:0]  sum;
  logic [KW-1:0]  tot;
  logic           is_last;
  logic           in_zero;
  logic [SW-1:0]  rd_idx;
  logic           out_free;
  logic           load_char;
  logic           ram_re;

  // ---------------------------------------------------------------------------
  // Request intake and pass bookkeeping
  // ---------------------------------------------------------------------------
  always_comb begin
    accept   = data_valid && data_ready;
    // Bytes past MAX_BYTES are the most significant; drop them.
    store    = byte_count < CW'(MAX_BYTES);
    stored_n = store ? byte_count + 1'b1 : byte_count;
    if (!store) begin
      zrun_n = zrun;
    end else if (data_byte == 8'd0) begin
      zrun_n = zrun + 1'b1;
    end else begin
      zrun_n = '0;
    end

    // The top cell leaves the row each cycle of a pass; its quotient enters cell 0.
    pass_end = (state == S_DIV) && (cyc == PW'(MAX_BYTES - 1));
    more     = nz || (quo != 8'd0);

    // Characters to emit: leading ones plus digits, clipped to MAX_CHARS.
    sum      = SW'(zeros) + SW'(dcnt);
    tot      = (sum > SW'(MAX_CHARS)) ? KW'(MAX_CHARS) : sum[KW-1:0];
    is_last  = ({1'b0, k} + 1'b1) == {1'b0, tot};
    in_zero  = SW'(k) < SW'(zeros);
    // Digits sit least significant first; read from the top down.
    rd_idx   = SW'(dcnt) + SW'(zeros) - SW'(k) - SW'(1);

    out_free  = !char_valid || char_ready;
    load_char = (state == S_WAIT) && out_free;
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    data_ready = 1'b0;
    ram_re     = 1'b0;
    case (state)
      S_LOAD: begin
        data_ready = 1'b1;
        if (accept && last_byte) begin
          // An all-zero number has no digits; go straight to the ones.
          state_next = (zrun_n == stored_n) ? S_FETCH : S_DIV;
        end
      end
      S_DIV: begin
        if (pass_end && !more) begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        ram_re     = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (load_char) begin
          state_next = is_last ? S_LOAD : S_FETCH;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      zrun       <= '0;
      zeros      <= '0;
      dcnt       <= '0;
      k          <= '0;
      cyc        <= '0;
      rem        <= '0;
      nz         <= 1'b0;
      char_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (last_byte) begin
          // Close the request: latch leading zeros, arm a fresh encoding.
          byte_count <= '0;
          zrun       <= '0;
          zeros      <= zrun_n;
          dcnt       <= '0;
          k          <= '0;
          cyc        <= '0;
          rem        <= '0;
          nz         <= 1'b0;
        end else begin
          byte_count <= stored_n;
          zrun       <= zrun_n;
        end
      end
      if (state == S_DIV) begin
        if (pass_end) begin
          // Remainder of the last byte is the next digit; restart the pass.
          cyc  <= '0;
          rem  <= '0;
          nz   <= 1'b0;
          dcnt <= dcnt + 1'b1;
        end else begin
          cyc  <= cyc + 1'b1;
          rem  <= rem_out;
          nz   <= more;
        end
      end
      if (load_char) begin
        char_valid <= 1'b1;
        k          <= k + 1'b1;
      end else if (char_ready) begin
        char_valid <= 1'b0;
      end
    end
  end

  // Output register: holds while the consumer stalls, frees the intake side.
  always_ff @(posedge clk) begin
    if (load_char) begin
      out_char  <= in_zero ? B58_ONE : b58_char(rdata);
      last_char <= is_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Byte cell row: cell i holds byte i of the number during load, and the row
  // rotates toward the top during a pass so the quotient ends where it began.
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < MAX_BYTES; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cell_in[i] = quo;
    end else begin : g_body
      assign cell_in[i] = cell_q[i-1];
    end

    always_comb begin
      cell_ctl[i].shift = (state == S_DIV);
      cell_ctl[i].load  = accept && store && (byte_count == CW'(i));
      cell_ctl[i].clear = accept && (byte_count == '0);
    end

    b58_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[i]),
      .data_byte (data_byte),
      .shift_in  (cell_in[i]),
      .value     (cell_q[i])
    );
  end

  // One byte of long division by 58 per cycle.
  b58_div58 u_div (
    .rem_in  (rem),
    .byte_in (cell_q[MAX_BYTES-1]),
    .quo     (quo),
    .rem_out (rem_out)
  );

  // Digit store, least significant digit at address 0.
  b58_ram #(
    .WIDTH (6),
    .DEPTH (DIG_DEPTH)
  ) u_digits (
    .clk   (clk),
    .we    (pass_end),
    .waddr (dcnt[AW-1:0]),
    .wdata (rem_out),
    .re    (ram_re),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rdata)
  );

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `B58_ASSERT_NOW(a_digit_bound, 1'b1, dcnt <= DCW'(DIG_DEPTH), "digit count past store depth")
  `B58_ASSERT_NOW(a_byte_bound, 1'b1, byte_count <= CW'(MAX_BYTES), "byte count past cell row")
  `B58_ASSERT_NEXT(a_pass_done, pass_end && !more, state == S_FETCH, "zero quotient did not end passes")
  `B58_ASSERT_NEXT(a_last_idle, load_char && is_last, state == S_LOAD && last_char, "final char not flagged")
  `B58_ASSERT_NEXT(a_lead_one, load_char && in_zero, out_char == B58_ONE, "leading zero byte not sent as one")

endmodule
